### rtl/register_vm_execute_assert.svh
// assertion macros for the register vm execute block
`ifndef REGISTER_VM_EXECUTE_ASSERT_SVH
`define REGISTER_VM_EXECUTE_ASSERT_SVH

`define RVM_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

`define RVM_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

### rtl/rvm_pkg.sv
`default_nettype none
package rvm_pkg;

   localparam int DataWords = 4096;
   localparam int RetDepth  = 256;
   localparam int NumRegs   = 18;
   localparam int SpPos     = 16;
   localparam int BpPos     = 17;

   typedef struct packed {
      logic [7:0]  mode;
      logic [7:0]  reg_a;
      logic [7:0]  reg_b;
      logic [7:0]  reg_c;
      logic [31:0] literal_word;
   } req_type;

   typedef struct packed {
      logic [15:0]        next_pc;
      logic               out_valid;
      logic signed [31:0] out_value;
      logic               halted;
      logic [2:0]         error_code;
   } rsp_type;

   typedef enum logic [2:0] {
      ERR_NONE    = 3'd0,
      ERR_OPCODE  = 3'd1,
      ERR_DIVZERO = 3'd2,
      ERR_BADREG  = 3'd3,
      ERR_OVERFL  = 3'd4,
      ERR_UNDERFL = 3'd5,
      ERR_UNSUPP  = 3'd6
   } err_type;

   localparam logic [7:0] OP_MOV   = 8'h00;
   localparam logic [7:0] OP_LDI   = 8'h01;
   localparam logic [7:0] OP_JZ    = 8'h02;
   localparam logic [7:0] OP_JP    = 8'h03;
   localparam logic [7:0] OP_OUT   = 8'h04;
   localparam logic [7:0] OP_ADD   = 8'h05;
   localparam logic [7:0] OP_ADDI  = 8'h06;
   localparam logic [7:0] OP_SUB   = 8'h07;
   localparam logic [7:0] OP_SUBI  = 8'h08;
   localparam logic [7:0] OP_MUL   = 8'h09;
   localparam logic [7:0] OP_MULI  = 8'h0A;
   localparam logic [7:0] OP_DIV   = 8'h0B;
   localparam logic [7:0] OP_DIVI  = 8'h0C;
   localparam logic [7:0] OP_MOD   = 8'h0D;
   localparam logic [7:0] OP_MODI  = 8'h0E;
   localparam logic [7:0] OP_LDL   = 8'h0F;
   localparam logic [7:0] OP_HALT  = 8'h10;
   localparam logic [7:0] OP_CALL  = 8'h11;
   localparam logic [7:0] OP_RET   = 8'h12;
   localparam logic [7:0] OP_STD   = 8'h13;
   localparam logic [7:0] OP_LDD   = 8'h14;
   localparam logic [7:0] OP_JNZ   = 8'h15;
   localparam logic [7:0] OP_EQ    = 8'h16;
   localparam logic [7:0] OP_LT    = 8'h17;
   localparam logic [7:0] OP_LE    = 8'h18;
   localparam logic [7:0] OP_GT    = 8'h19;
   localparam logic [7:0] OP_GE    = 8'h1A;
   localparam logic [7:0] OP_UNS0  = 8'h1B;
   localparam logic [7:0] OP_UNS1  = 8'h1C;
   localparam logic [7:0] OP_LDR   = 8'h1D;
   localparam logic [7:0] OP_STR   = 8'h1E;
   localparam logic [7:0] OP_PUSH  = 8'h1F;
   localparam logic [7:0] OP_POP   = 8'h20;
   localparam logic [7:0] OP_LDB   = 8'h21;
   localparam logic [7:0] OP_STB   = 8'h22;

   // controller commands to the datapath
   typedef struct packed {
      logic latch;
      logic check;
      logic div_start;
      logic mem_read;
      logic commit;
      logic fault;
      logic idle;
   } cmd_type;

   typedef struct packed {
      logic      div_done;
      logic      skip;
      logic      is_div;
      logic      is_mem_read;
      logic      bad;
   } stat_type;

endpackage
`default_nettype wire

### rtl/rvm_divider.sv
`default_nettype none
module rvm_divider (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   input  wire logic [31:0] dividend,
   input  wire logic [31:0] divisor,
   output logic             done,
   output logic [31:0]      quotient,
   output logic [31:0]      remainder
);

   logic [31:0] q_ff, q_in;
   logic [32:0] r_ff, r_in;
   logic [31:0] d_ff, d_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in;
   logic        nq_ff, nq_in, nr_ff, nr_in;
   logic [32:0] trial;
   logic [32:0] shifted;

   always_comb begin
      q_in    = q_ff;
      r_in    = r_ff;
      d_in    = d_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      nq_in   = nq_ff;
      nr_in   = nr_ff;
      shifted = {r_ff[31:0], q_ff[31]};
      trial   = shifted - {1'b0, d_ff};
      if (start) begin
         q_in    = dividend[31] ? (32'd0 - dividend) : dividend;
         d_in    = divisor[31] ? (32'd0 - divisor) : divisor;
         r_in    = '0;
         cnt_in  = 6'd32;
         busy_in = 1'b1;
         nq_in   = dividend[31] ^ divisor[31];
         nr_in   = dividend[31];
      end else if (busy_ff) begin
         if (!trial[32]) begin
            r_in = trial;
            q_in = {q_ff[30:0], 1'b1};
         end else begin
            r_in = shifted;
            q_in = {q_ff[30:0], 1'b0};
         end
         cnt_in = cnt_ff - 6'd1;
         if (cnt_ff == 6'd1) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
      q_ff  <= q_in;
      r_ff  <= r_in;
      d_ff  <= d_in;
      nq_ff <= nq_in;
      nr_ff <= nr_in;
   end

   assign done      = !busy_ff;
   assign quotient  = nq_ff ? (32'd0 - q_ff) : q_ff;
   assign remainder = nr_ff ? (32'd0 - r_ff[31:0]) : r_ff[31:0];

endmodule
`default_nettype wire

### rtl/rvm_datapath.sv
`default_nettype none
module rvm_datapath #(
   parameter int DATA_WORDS = rvm_pkg::DataWords,
   parameter int RET_DEPTH  = rvm_pkg::RetDepth
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire rvm_pkg::cmd_type cmd,
   output rvm_pkg::stat_type     stat,
   input  wire rvm_pkg::req_type req,
   input  wire logic [15:0]      csr_wdata,
   input  wire logic             csr_we,
   output rvm_pkg::rsp_type      result
);

   localparam int DW = $clog2(DATA_WORDS);
   localparam int RW = $clog2(RET_DEPTH);

   logic [31:0] regs_ff [rvm_pkg::NumRegs];
   logic [31:0] dmem [DATA_WORDS];
   logic [15:0] rstack [RET_DEPTH];
   logic [RW:0] depth_ff;
   logic [15:0] pc_ff;
   logic [15:0] plen_ff;
   logic        stopped_ff;

   rvm_pkg::req_type ir_ff;
   logic [31:0] ra_ff, rb_ff, sp_ff, imm_ff;
   logic [31:0] mrd_ff, rsrd_ff;
   logic [31:0] mul_ff;
   logic [31:0] addr_ff;
   rvm_pkg::err_type err_ff, err_in;
   logic        skip_ff, skip_in;

   logic [31:0] imm, va, vb;
   logic [2:0]  uses;
   logic        div_done;
   logic [31:0] quo, rem;
   logic [31:0] opnd2;

   assign imm = {{16{req.reg_c[7]}}, req.reg_c, req.reg_b};

   function automatic logic [31:0] rd(input logic [7:0] idx,
                                      input logic [31:0] r [rvm_pkg::NumRegs]);
      logic [31:0] v;
      v = '0;
      for (int i = 0; i < rvm_pkg::NumRegs; i++) begin
         if (idx == 8'(i)) begin
            v = r[i];
         end
      end
      return v;
   endfunction

   function automatic logic [15:0] starget(input logic [31:0] lit);
      logic [31:0] s;
      s = $signed(lit) >>> 2;
      if (lit[31] && lit[1:0] != 2'b00) begin
         s = s + 32'd1;
      end
      return s[15:0];
   endfunction

   assign va = rd(req.reg_a, regs_ff);
   assign vb = rd(req.reg_b, regs_ff);

   // decode, register check and fault detection
   always_comb begin
      uses   = 3'b000;
      err_in = rvm_pkg::ERR_NONE;
      case (req.mode) inside
         rvm_pkg::OP_MOV, rvm_pkg::OP_LDR, rvm_pkg::OP_STR: uses = 3'b011;
         rvm_pkg::OP_LDI, rvm_pkg::OP_JZ, rvm_pkg::OP_JNZ, rvm_pkg::OP_OUT,
         rvm_pkg::OP_ADDI, rvm_pkg::OP_SUBI, rvm_pkg::OP_MULI, rvm_pkg::OP_DIVI,
         rvm_pkg::OP_MODI, rvm_pkg::OP_LDL, rvm_pkg::OP_STD, rvm_pkg::OP_LDD,
         rvm_pkg::OP_PUSH, rvm_pkg::OP_POP, rvm_pkg::OP_LDB, rvm_pkg::OP_STB:
            uses = 3'b001;
         rvm_pkg::OP_ADD, rvm_pkg::OP_SUB, rvm_pkg::OP_MUL, rvm_pkg::OP_DIV,
         rvm_pkg::OP_MOD, [rvm_pkg::OP_EQ:rvm_pkg::OP_GE]: uses = 3'b111;
         rvm_pkg::OP_JP, rvm_pkg::OP_HALT, rvm_pkg::OP_CALL, rvm_pkg::OP_RET:
            uses = 3'b000;
         rvm_pkg::OP_UNS0, rvm_pkg::OP_UNS1: err_in = rvm_pkg::ERR_UNSUPP;
         default: err_in = rvm_pkg::ERR_OPCODE;
      endcase
      if (err_in == rvm_pkg::ERR_NONE &&
          ((uses[0] && req.reg_a >= 8'(rvm_pkg::NumRegs)) ||
           (uses[1] && req.reg_b >= 8'(rvm_pkg::NumRegs)) ||
           (uses[2] && req.reg_c >= 8'(rvm_pkg::NumRegs)))) begin
         err_in = rvm_pkg::ERR_BADREG;
      end
      if (err_in == rvm_pkg::ERR_NONE) begin
         if ((req.mode == rvm_pkg::OP_DIV || req.mode == rvm_pkg::OP_MOD) && vb == '0) begin
            err_in = rvm_pkg::ERR_DIVZERO;
         end
         if ((req.mode == rvm_pkg::OP_DIVI || req.mode == rvm_pkg::OP_MODI) &&
             imm == '0) begin
            err_in = rvm_pkg::ERR_DIVZERO;
         end
         if (req.mode == rvm_pkg::OP_CALL && depth_ff >= (RW+1)'(RET_DEPTH)) begin
            err_in = rvm_pkg::ERR_OVERFL;
         end
         if (req.mode == rvm_pkg::OP_RET && depth_ff == '0) begin
            err_in = rvm_pkg::ERR_UNDERFL;
         end
      end
      skip_in = stopped_ff || (pc_ff >= plen_ff);
   end

   assign opnd2 = (ir_ff.mode == rvm_pkg::OP_DIVI || ir_ff.mode == rvm_pkg::OP_MODI ||
                   ir_ff.mode == rvm_pkg::OP_ADDI || ir_ff.mode == rvm_pkg::OP_SUBI ||
                   ir_ff.mode == rvm_pkg::OP_MULI) ? imm_ff : rb_ff;

   rvm_divider u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (cmd.div_start),
      .dividend  (ra_ff),
      .divisor   (opnd2),
      .done      (div_done),
      .quotient  (quo),
      .remainder (rem)
   );

   // latch operands and memory address
   logic [31:0] addr_in;
   always_comb begin
      case (req.mode)
         rvm_pkg::OP_LDR: addr_in = va;
         rvm_pkg::OP_STR: addr_in = vb;
         rvm_pkg::OP_PUSH: addr_in = regs_ff[rvm_pkg::SpPos];
         rvm_pkg::OP_POP: addr_in = regs_ff[rvm_pkg::SpPos] - 32'd4;
         rvm_pkg::OP_LDB, rvm_pkg::OP_STB: addr_in = regs_ff[rvm_pkg::BpPos] + imm;
         default: addr_in = req.literal_word;
      endcase
   end

   logic [DW-1:0] widx;
   assign widx = addr_ff[DW+1:2];

   always_ff @(posedge clock) begin
      if (cmd.latch) begin
         ir_ff   <= req;
         ra_ff   <= va;
         rb_ff   <= vb;
         imm_ff  <= imm;
         addr_ff <= addr_in;
         err_ff  <= err_in;
         skip_ff <= skip_in;
         sp_ff   <= regs_ff[rvm_pkg::SpPos];
         rsrd_ff <= {16'd0, rstack[RW'(depth_ff - (RW+1)'(1))]};
      end
      if (cmd.mem_read) begin
         mrd_ff <= dmem[widx];
      end
      if (cmd.check) begin
         mul_ff <= ra_ff * opnd2;
      end
      if (cmd.commit && ir_ff.mode == rvm_pkg::OP_CALL) begin
         rstack[RW'(depth_ff)] <= pc_ff + 16'd2;
      end
      if (cmd.commit) begin
         case (ir_ff.mode)
            rvm_pkg::OP_STD, rvm_pkg::OP_STR, rvm_pkg::OP_PUSH, rvm_pkg::OP_STB:
               dmem[widx] <= ra_ff;
            default: ;
         endcase
      end
   end

   // write back
   logic [31:0] wval;
   logic [7:0]  widx_r;
   logic        wen;
   logic [15:0] np;
   logic        hop;
   always_comb begin
      wval   = '0;
      widx_r = ir_ff.reg_c;
      wen    = 1'b0;
      hop    = 1'b0;
      np     = pc_ff + 16'd1;
      case (ir_ff.mode)
         rvm_pkg::OP_MOV: begin wen = 1'b1; widx_r = ir_ff.reg_b; wval = ra_ff; end
         rvm_pkg::OP_LDI: begin wen = 1'b1; widx_r = ir_ff.reg_a; wval = imm_ff; end
         rvm_pkg::OP_JZ: np = (ra_ff == '0) ? starget(ir_ff.literal_word) : pc_ff + 16'd2;
         rvm_pkg::OP_JNZ: np = (ra_ff != '0) ? starget(ir_ff.literal_word) : pc_ff + 16'd2;
         rvm_pkg::OP_JP: np = starget(ir_ff.literal_word);
         rvm_pkg::OP_ADD: begin wen = 1'b1; wval = ra_ff + rb_ff; end
         rvm_pkg::OP_ADDI: begin wen = 1'b1; widx_r = ir_ff.reg_a; wval = ra_ff + imm_ff; end
         rvm_pkg::OP_SUB: begin wen = 1'b1; wval = ra_ff - rb_ff; end
         rvm_pkg::OP_SUBI: begin wen = 1'b1; widx_r = ir_ff.reg_a; wval = ra_ff - imm_ff; end
         rvm_pkg::OP_MUL: begin wen = 1'b1; wval = mul_ff; end
         rvm_pkg::OP_MULI: begin wen = 1'b1; widx_r = ir_ff.reg_a; wval = mul_ff; end
         rvm_pkg::OP_DIV: begin wen = 1'b1; wval = quo; end
         rvm_pkg::OP_DIVI: begin wen = 1'b1; widx_r = ir_ff.reg_a; wval = quo; end
         rvm_pkg::OP_MOD: begin wen = 1'b1; wval = rem; end
         rvm_pkg::OP_MODI: begin wen = 1'b1; widx_r = ir_ff.reg_a; wval = rem; end
         rvm_pkg::OP_LDL: begin
            wen = 1'b1; widx_r = ir_ff.reg_a; wval = ir_ff.literal_word;
            np = pc_ff + 16'd2;
         end
         rvm_pkg::OP_HALT: hop = 1'b1;
         rvm_pkg::OP_CALL: np = ir_ff.literal_word[17:2];
         rvm_pkg::OP_RET: np = rsrd_ff[15:0];
         rvm_pkg::OP_STD: np = pc_ff + 16'd2;
         rvm_pkg::OP_LDD: begin
            wen = 1'b1; widx_r = ir_ff.reg_a; wval = mrd_ff; np = pc_ff + 16'd2;
         end
         rvm_pkg::OP_EQ: begin wen = 1'b1; wval = {31'd0, ra_ff == rb_ff}; end
         rvm_pkg::OP_LT: begin wen = 1'b1; wval = {31'd0, $signed(ra_ff) < $signed(rb_ff)}; end
         rvm_pkg::OP_LE: begin wen = 1'b1; wval = {31'd0, $signed(ra_ff) <= $signed(rb_ff)}; end
         rvm_pkg::OP_GT: begin wen = 1'b1; wval = {31'd0, $signed(ra_ff) > $signed(rb_ff)}; end
         rvm_pkg::OP_GE: begin wen = 1'b1; wval = {31'd0, $signed(ra_ff) >= $signed(rb_ff)}; end
         rvm_pkg::OP_LDR: begin wen = 1'b1; widx_r = ir_ff.reg_b; wval = mrd_ff; end
         rvm_pkg::OP_POP, rvm_pkg::OP_LDB: begin
            wen = 1'b1; widx_r = ir_ff.reg_a; wval = mrd_ff;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < rvm_pkg::NumRegs; i++) begin
            regs_ff[i] <= '0;
         end
         regs_ff[rvm_pkg::SpPos] <= 32'h8000_0000;
         regs_ff[rvm_pkg::BpPos] <= 32'h8000_0000;
         pc_ff      <= '0;
         depth_ff   <= '0;
         stopped_ff <= 1'b0;
         plen_ff    <= '0;
      end else begin
         if (csr_we) begin
            plen_ff <= csr_wdata;
         end
         if (cmd.idle) begin
            stopped_ff <= 1'b1;
         end
         if (cmd.fault) begin
            stopped_ff <= 1'b1;
         end
         if (cmd.commit) begin
            pc_ff <= np;
            if (hop || np >= plen_ff) begin
               stopped_ff <= 1'b1;
            end
            if (ir_ff.mode == rvm_pkg::OP_PUSH) begin
               regs_ff[rvm_pkg::SpPos] <= sp_ff + 32'd4;
            end
            if (ir_ff.mode == rvm_pkg::OP_POP) begin
               regs_ff[rvm_pkg::SpPos] <= sp_ff - 32'd4;
            end
            if (wen) begin
               regs_ff[5'(widx_r)] <= wval;
            end
            if (ir_ff.mode == rvm_pkg::OP_CALL) begin
               depth_ff <= depth_ff + (RW+1)'(1);
            end
            if (ir_ff.mode == rvm_pkg::OP_RET) begin
               depth_ff <= depth_ff - (RW+1)'(1);
            end
         end
      end
   end

   // result record, built in the cycle the controller ends the transaction
   always_ff @(posedge clock) begin
      if (cmd.idle) begin
         result <= '{next_pc: pc_ff, out_valid: 1'b0, out_value: '0,
                     halted: 1'b1, error_code: rvm_pkg::ERR_NONE};
      end else if (cmd.fault) begin
         result <= '{next_pc: pc_ff, out_valid: 1'b0, out_value: '0,
                     halted: 1'b1, error_code: err_ff};
      end else if (cmd.commit) begin
         result <= '{next_pc: np, out_valid: ir_ff.mode == rvm_pkg::OP_OUT,
                     out_value: (ir_ff.mode == rvm_pkg::OP_OUT) ? ra_ff : '0,
                     halted: hop || np >= plen_ff, error_code: rvm_pkg::ERR_NONE};
      end
   end

   always_comb begin
      stat.div_done    = div_done;
      stat.skip        = skip_ff;
      stat.bad         = err_ff != rvm_pkg::ERR_NONE;
      stat.is_div      = ir_ff.mode == rvm_pkg::OP_DIV || ir_ff.mode == rvm_pkg::OP_DIVI ||
                         ir_ff.mode == rvm_pkg::OP_MOD || ir_ff.mode == rvm_pkg::OP_MODI;
      stat.is_mem_read = ir_ff.mode == rvm_pkg::OP_LDD || ir_ff.mode == rvm_pkg::OP_LDR ||
                         ir_ff.mode == rvm_pkg::OP_POP || ir_ff.mode == rvm_pkg::OP_LDB;
   end

endmodule
`default_nettype wire

### rtl/rvm_control.sv
`default_nettype none
module rvm_control (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_ready,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   input  wire rvm_pkg::stat_type stat,
   output rvm_pkg::cmd_type       cmd
);

   typedef enum logic [4:0] {
      ST_IDLE  = 5'b00001,
      ST_CHECK = 5'b00010,
      ST_DIV   = 5'b00100,
      ST_MEM   = 5'b01000,
      ST_DONE  = 5'b10000
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff;
      cmd          = '0;
      req_ready    = 1'b0;
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            cmd.latch = req_valid;
            if (req_valid) begin
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            cmd.check = 1'b1;
            if (stat.skip || stat.bad) begin
               state_in = ST_DONE;
            end else if (stat.is_div) begin
               cmd.div_start = 1'b1;
               state_in = ST_DIV;
            end else if (stat.is_mem_read) begin
               cmd.mem_read = 1'b1;
               state_in = ST_DONE;
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_DIV: begin
            if (stat.div_done) begin
               state_in = ST_DONE;
            end
         end
         ST_MEM: state_in = ST_DONE;
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.idle   = stat.skip;
               cmd.fault  = !stat.skip && stat.bad;
               cmd.commit = !stat.skip && !stat.bad;
               rsp_valid_in = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule
`default_nettype wire

### rtl/register_vm_execute.sv
`default_nettype none
// Executes one vm instruction per transaction: most opcodes pass through accept, check
// and commit, with the result valid in the cycle after commit; divide and modulo also
// wait on the 32-step bit-serial divider. A result waiting on rsp_ready holds the next
// commit. Registers, pc and return depth live in flip-flops; data memory and the return
// stack are single-port memories. After halt, a fault or pc past program_length every
// transaction answers halted with next_pc unchanged. csr writes set program_length.
module register_vm_execute #(
   parameter int DATA_WORDS = rvm_pkg::DataWords,
   parameter int RET_DEPTH  = rvm_pkg::RetDepth
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_ready,
   input  wire rvm_pkg::req_type req_data,
   output logic                  rsp_valid,
   input  wire logic             rsp_ready,
   output rvm_pkg::rsp_type      rsp_data,
   input  wire logic             csr_we,
   input  wire logic [15:0]      csr_wdata
);

   rvm_pkg::cmd_type  cmd;
   rvm_pkg::stat_type stat;

   rvm_control u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   rvm_datapath #(
      .DATA_WORDS (DATA_WORDS),
      .RET_DEPTH  (RET_DEPTH)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .stat      (stat),
      .req       (req_data),
      .csr_wdata (csr_wdata),
      .csr_we    (csr_we),
      .result    (rsp_data)
   );

endmodule
`default_nettype wire

### rtl/rvm_checker.sv
`default_nettype none
`include "register_vm_execute_assert.svh"
module rvm_checker (
   input wire logic             clock,
   input wire logic             reset,
   input wire logic             req_valid,
   input wire logic             req_ready,
   input wire logic             rsp_valid,
   input wire logic             rsp_ready,
   input wire rvm_pkg::rsp_type rsp_data
);

   `RVM_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid)
   `RVM_ASSERT_NEXT(a_rsp_stable, clock, reset, rsp_valid && !rsp_ready, $stable(rsp_data))
   `RVM_ASSERT_IMPL(a_err_halts, clock, reset, rsp_valid && rsp_data.error_code != rvm_pkg::ERR_NONE, rsp_data.halted)
   `RVM_ASSERT_IMPL(a_out_clean, clock, reset, rsp_valid && rsp_data.error_code != rvm_pkg::ERR_NONE, !rsp_data.out_valid)
   `RVM_ASSERT_NEXT(a_one_at_a_time, clock, reset, req_valid && req_ready, !req_ready)

endmodule

bind register_vm_execute rvm_checker u_chk (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);
`default_nettype wire
